@@ rtl/core/lht_pkg.sv @@
`default_nettype none

package lht_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // field widths
    localparam int ID_W     = 32;
    localparam int TIME_W   = 64;
    localparam int LAT_W    = 55;
    localparam int HCNT_W   = 64;
    localparam int STATUS_W = 2;
    localparam int BUCKET_W = 3;

    localparam int HIST_BINS = 5;
    localparam int NS_PER_US = 1000;

    // decoupling queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_END   = 1'b1;

    // bucket codes
    localparam logic [BUCKET_W-1:0] BKT_UNDER_1US    = 3'd0;
    localparam logic [BUCKET_W-1:0] BKT_UNDER_10US   = 3'd1;
    localparam logic [BUCKET_W-1:0] BKT_UNDER_100US  = 3'd2;
    localparam logic [BUCKET_W-1:0] BKT_UNDER_1000US = 3'd3;
    localparam logic [BUCKET_W-1:0] BKT_1000US_UP    = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED   = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_RECORDED = 2'd2,
        ST_NO_START = 2'd3
    } status_t;

    typedef struct packed {
        logic              operation;
        logic [ID_W-1:0]   event_id;
        logic [TIME_W-1:0] time_ns;
    } item_t;

endpackage

`default_nettype wire

@@ rtl/core/lht_if.sv @@
`default_nettype none

interface lht_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [lht_pkg::ID_W-1:0]    event_id;
    logic [lht_pkg::TIME_W-1:0]  time_ns;

    modport source (output valid, output operation, output event_id, output time_ns,
                    input ready);
    modport sink   (input valid, input operation, input event_id, input time_ns,
                    output ready);
endinterface

interface lht_out_if;
    logic                          valid;
    logic                          ready;
    logic [lht_pkg::STATUS_W-1:0]  status;
    logic [lht_pkg::BUCKET_W-1:0]  bucket;
    logic [lht_pkg::LAT_W-1:0]     latency_us;
    logic [lht_pkg::HCNT_W-1:0]    count_under_1us;
    logic [lht_pkg::HCNT_W-1:0]    count_under_10us;
    logic [lht_pkg::HCNT_W-1:0]    count_under_100us;
    logic [lht_pkg::HCNT_W-1:0]    count_under_1000us;
    logic [lht_pkg::HCNT_W-1:0]    count_1000us_up;

    modport source (output valid, output status, output bucket, output latency_us,
                    output count_under_1us, output count_under_10us,
                    output count_under_100us, output count_under_1000us,
                    output count_1000us_up, input ready);
    modport sink   (input valid, input status, input bucket, input latency_us,
                    input count_under_1us, input count_under_10us,
                    input count_under_100us, input count_under_1000us,
                    input count_1000us_up, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lht_queue.sv @@
`default_nettype none

module lht_queue (
    input  logic           clk,
    input  logic           rst_n,
    lht_in_if.sink         in_ch,
    output lht_pkg::item_t head,
    output logic           head_valid,
    input  logic           pop
);
    import lht_pkg::*;

    item_t              fifo_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push;
    item_t              in_item;

    assign in_ch.ready = (count_reg != QCNT_W'(QDEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign head_valid  = (count_reg != '0);
    assign head        = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        in_item.operation = in_ch.operation;
        in_item.event_id  = in_ch.event_id;
        in_item.time_ns   = in_ch.time_ns;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (count_reg == QCNT_W'($past(count_reg) + QCNT_W'($past(push))
                                               - QCNT_W'($past(pop)))))
        else $error("queue count lost track of push/pop");

endmodule

`default_nettype wire

@@ rtl/core/lht_div.sv @@
`default_nettype none

module lht_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lht_pkg::TIME_W-1:0]  dividend,
    output logic [lht_pkg::TIME_W-1:0]  quotient,
    output logic                        done
);
    import lht_pkg::*;

    // x / 1000 == (x / 8) / 125. The 61-bit x / 8 times ceil(2^68 / 125),
    // shifted right by 68, is exact for every 64-bit x. The product is built
    // from four 32 x 32 partial products, one per cycle, each registered and then added into the accumulator.
    localparam int PRE_SHIFT = 3;
    localparam int Q_SHIFT   = 68;
    localparam int ACC_W     = 2 * TIME_W;
    localparam int HALF_W    = TIME_W / 2;
    localparam int STEP_W    = 3;
    localparam logic [TIME_W-1:0] RECIP =
        TIME_W'(((ACC_W'(1) << (Q_SHIFT + PRE_SHIFT)) / ACC_W'(NS_PER_US)) + ACC_W'(1));
    localparam logic [STEP_W-1:0] LAST_STEP = 3'd4;

    logic [TIME_W-1:0] y_reg, y_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [TIME_W-1:0] pp_reg, pp_next;
    logic [1:0]        pp_pos_reg, pp_pos_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [TIME_W-1:0] mul_p;
    logic [ACC_W-1:0]  addend;

    // step bit 1 picks the dividend half, bit 0 the reciprocal half
    assign mul_a    = step_reg[1] ? y_reg[TIME_W-1:HALF_W] : y_reg[HALF_W-1:0];
    assign mul_b    = step_reg[0] ? RECIP[TIME_W-1:HALF_W] : RECIP[HALF_W-1:0];
    assign mul_p    = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
    assign quotient = TIME_W'(acc_reg[ACC_W-1:Q_SHIFT]);
    assign done     = done_reg;

    // place the held partial product at its weight
    always_comb
    begin
        if (pp_pos_reg[1] && pp_pos_reg[0])
            addend = {pp_reg, {TIME_W{1'b0}}};
        else if (pp_pos_reg[1] || pp_pos_reg[0])
            addend = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
        else
            addend = {{TIME_W{1'b0}}, pp_reg};
    end

    always_comb
    begin
        y_next      = y_reg;
        acc_next    = acc_reg;
        pp_next     = pp_reg;
        pp_pos_next = pp_pos_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            y_next    = dividend >> PRE_SHIFT;
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (step_reg != '0)
                acc_next = acc_reg + addend;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                pp_next     = mul_p;
                pp_pos_next = step_reg[1:0];
                step_next   = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg      <= y_next;
        acc_reg    <= acc_next;
        pp_reg     <= pp_next;
        pp_pos_reg <= pp_pos_next;
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

@@ rtl/core/lht_engine.sv @@
`default_nettype none

module lht_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  lht_pkg::item_t head,
    input  logic           head_valid,
    output logic           pop,
    lht_out_if.source      out_ch
);
    import lht_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_READ   = 6'b001000,
        S_DIV    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    state_t             state_reg, state_next;
    item_t              cmd_reg, cmd_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               issue_reg, issue_next;
    logic               chk_reg, chk_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [TABLE_ENTRIES-1:0] slot_valid_reg, slot_valid_next;

    status_t            status_reg, status_next;
    logic [BUCKET_W-1:0] bucket_reg, bucket_next;
    logic [LAT_W-1:0]   lat_reg, lat_next;
    logic [HCNT_W-1:0]  counts_reg [HIST_BINS];
    logic [HCNT_W-1:0]  counts_next [HIST_BINS];

    logic               out_valid_reg, out_valid_next;
    logic               out_load;

    // slot memories
    logic [ID_W-1:0]    key_mem  [TABLE_ENTRIES];
    logic [TIME_W-1:0]  time_mem [TABLE_ENTRIES];
    logic [ID_W-1:0]    key_rd_reg;
    logic [TIME_W-1:0]  time_rd_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   wr_idx;

    logic               div_start;
    logic [TIME_W-1:0]  div_quo;
    logic               div_done;
    logic [LAT_W-1:0]   div_lat;
    logic [BUCKET_W-1:0] div_bkt;

    function automatic logic [BUCKET_W-1:0] decade_of(input logic [LAT_W-1:0] us);
        logic [BUCKET_W-1:0] b;
        if (us < LAT_W'(1))
            b = BKT_UNDER_1US;
        else if (us < LAT_W'(10))
            b = BKT_UNDER_10US;
        else if (us < LAT_W'(100))
            b = BKT_UNDER_100US;
        else if (us < LAT_W'(NS_PER_US))
            b = BKT_UNDER_1000US;
        else
            b = BKT_1000US_UP;
        return b;
    endfunction

    lht_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cmd_reg.time_ns - time_rd_reg),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign div_lat  = div_quo[LAT_W-1:0];
    assign div_bkt  = decade_of(div_lat);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        issue_next      = issue_reg;
        chk_next        = 1'b0;
        cmp_idx_next    = idx_reg;
        found_next      = found_reg;
        match_idx_next  = match_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        slot_valid_next = slot_valid_reg;
        status_next     = status_reg;
        bucket_next     = bucket_reg;
        lat_next        = lat_reg;
        for (int k = 0; k < HIST_BINS; k++)
        begin
            counts_next[k] = counts_reg[k];
        end
        pop       = 1'b0;
        mem_we    = 1'b0;
        wr_idx    = free_idx_reg;
        div_start = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop             = 1'b1;
                    cmd_next        = head;
                    idx_next        = '0;
                    issue_next      = 1'b1;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue side: one key read per cycle, free slot from valid bits
                if (issue_reg)
                begin
                    chk_next = 1'b1;
                    if (!slot_valid_reg[idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                        issue_next = 1'b0;
                    else
                        idx_next = idx_reg + 1'b1;
                end
                // compare side: key data lands in the cycle after issue
                if (chk_reg)
                begin
                    if (slot_valid_reg[cmp_idx_reg] && (key_rd_reg == cmd_reg.event_id)
                        && !found_reg)
                    begin
                        found_next     = 1'b1;
                        match_idx_next = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == LAST_IDX)
                        state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                bucket_next = BKT_UNDER_1US;
                lat_next    = '0;
                if (cmd_reg.operation == OP_START)
                begin
                    if (found_reg || free_found_reg)
                    begin
                        mem_we      = 1'b1;
                        wr_idx      = found_reg ? match_idx_reg : free_idx_reg;
                        slot_valid_next[wr_idx] = 1'b1;
                        status_next = ST_STORED;
                    end
                    else
                    begin
                        status_next = ST_DROPPED;
                    end
                    state_next = S_DONE;
                end
                else if (found_reg)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    status_next = ST_NO_START;
                    state_next  = S_DONE;
                end
            end
            S_READ:
            begin
                div_start = 1'b1;
                slot_valid_next[match_idx_reg] = 1'b0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    status_next = ST_RECORDED;
                    bucket_next = div_bkt;
                    lat_next    = div_lat;
                    for (int k = 0; k < HIST_BINS; k++)
                    begin
                        if (div_bkt == BUCKET_W'(k))
                            counts_next[k] = counts_reg[k] + 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_reg      <= 1'b0;
            chk_reg        <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < HIST_BINS; k++)
            begin
                counts_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            chk_reg        <= chk_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
            for (int k = 0; k < HIST_BINS; k++)
            begin
                counts_reg[k] <= counts_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        status_reg    <= status_next;
        bucket_reg    <= bucket_next;
        lat_reg       <= lat_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[wr_idx]  <= cmd_reg.event_id;
            time_mem[wr_idx] <= cmd_reg.time_ns;
        end
        key_rd_reg  <= key_mem[idx_reg];
        time_rd_reg <= time_mem[match_idx_reg];
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch.status             <= status_reg;
            out_ch.bucket             <= bucket_reg;
            out_ch.latency_us         <= lat_reg;
            out_ch.count_under_1us    <= counts_reg[0];
            out_ch.count_under_10us   <= counts_reg[1];
            out_ch.count_under_100us  <= counts_reg[2];
            out_ch.count_under_1000us <= counts_reg[3];
            out_ch.count_1000us_up    <= counts_reg[4];
        end
    end

    assign out_ch.valid = out_valid_reg;

    a_read_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (found_reg && (cmd_reg.operation == OP_END)))
        else $error("timestamp read without a matching slot");

endmodule

`default_nettype wire

@@ rtl/core/latency_histogram_tracker_top.sv @@
// Latency histogram tracker.
// in_ch carries events: operation (start or end), a 32-bit id and a 64-bit ns
// timestamp. A start stores the timestamp for its id in a 64-slot table
// (overwrite if present, else lowest free slot, else dropped). An end looks up
// its id, frees the slot, divides the wrapped difference by 1000 and counts the
// microsecond latency into one of five decade buckets.
// out_ch returns one item per event: status, bucket, latency_us and all five
// histogram counts as they stand after the event.
// A two-entry queue takes items while the back end works. Each item scans
// the whole table, one key memory read per cycle; a recorded end then adds
// the timestamp read and the divide by 1000, a reciprocal multiply over four
// 32 x 32 partial products. One item is in work at a time.
// Reset clears the queue, all slot valid bits and the counters; no clearing
// pass is needed. A stalled receiver holds the result register; the engine then
// parks with its next result ready and the queue fills before in_ch.ready drops.
`default_nettype none

module latency_histogram_tracker_top (
    input  logic       clk,
    input  logic       rst_n,
    lht_in_if.sink     in_ch,
    lht_out_if.source  out_ch
);
    import lht_pkg::*;

    item_t head;
    logic  head_valid;
    logic  pop;

    // front end: accept and buffer events
    lht_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    // back end: table scan, latency divide, histogram, result register
    lht_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire
